// ===== hdl/wmmd_pkg.sv =====
// Shared types and constants of the min/max waveform decimator.
// No dependencies; imported by every module of the block.
`default_nettype none

package wmmd_pkg;

	// Build-time defaults for the top-level parameters
	localparam int DEF_MAX_BINS    = 16384;
	localparam int DEF_MAX_SAMPLES = 65536;
	localparam int DEF_SAMPLE_BITS = 24;

	// Fixed field widths
	localparam int SAMPLES_CFG_BITS = 17;
	localparam int BINS_CFG_BITS    = 15;
	localparam int CFG_DATA_BITS    = 17;
	localparam int CFG_IDX_BITS     = 2;
	localparam int OUT_BITS         = 22;
	localparam int BIN_INDEX_BITS   = 14;

	// Register map
	localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLES_PER_FRAME = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BINS_PER_FRAME    = 2'd1;

	localparam int RESET_SAMPLES = 1024;
	localparam int RESET_BINS    = 512;

	// Output clamp, 2^20 is full scale
	localparam int FULL_SCALE = 1048576;

	localparam int QUEUE_DEPTH = 4;

	// Per-sample tag produced by the front end
	typedef struct packed {
		logic                      close;  // sample ends a bin
		logic                      last;   // bin is the last of the frame
		logic [BIN_INDEX_BITS-1:0] index;
	} wmmd_ctrl_t;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} wmmd_div_stat_t;

endpackage

`default_nettype wire

// ===== hdl/wmmd_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Uses wmmd_pkg for the status struct.
`default_nettype none

module wmmd_div #(
	parameter int N_BITS = 17,
	parameter int D_BITS = 15
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [N_BITS-1:0]      dividend,
	input  logic [D_BITS-1:0]      divisor,
	output wmmd_pkg::wmmd_div_stat_t stat,
	output logic [N_BITS-1:0]      quotient,
	output logic [D_BITS-1:0]      remainder
);
	import wmmd_pkg::*;

	localparam int CW = $clog2(N_BITS + 1);

	logic [N_BITS-1:0] quo_q;
	logic [D_BITS-1:0] rem_q;
	logic [D_BITS-1:0] dvs_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [D_BITS:0]   shifted;
	logic [D_BITS:0]   diff;
	logic              ge;
	logic [D_BITS-1:0] rem_nxt;
	logic [N_BITS-1:0] quo_nxt;

	always_comb begin
		shifted = {rem_q, quo_q[N_BITS-1]};
		ge      = shifted >= {1'b0, dvs_q};
		diff    = shifted - {1'b0, dvs_q};
		rem_nxt = ge ? diff[D_BITS-1:0] : shifted[D_BITS-1:0];
		quo_nxt = {quo_q[N_BITS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== hdl/wmmd_queue.sv =====
// Small register FIFO between the front end and the back end.
// Generic width; no package content needed beyond the import.
`default_nettype none

module wmmd_queue #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	import wmmd_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else if (clear) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_data;
	end

	assign rd_data = slot_q[rd_ptr_q];
	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !clear |-> !full || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== hdl/wmmd_front.sv =====
// Front end: configuration registers, frame/bin boundary tracking, tagging.
// Uses wmmd_pkg and instantiates wmmd_div.
`default_nettype none

module wmmd_front #(
	parameter int MAX_BINS    = wmmd_pkg::DEF_MAX_BINS,
	parameter int MAX_SAMPLES = wmmd_pkg::DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = wmmd_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wmmd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [wmmd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic                                q_full,
	output logic                                push,
	output logic signed [SAMPLE_BITS-1:0]       push_sample,
	output wmmd_pkg::wmmd_ctrl_t                push_ctrl,
	output logic                                restart
);
	import wmmd_pkg::*;

	localparam int SW  = $clog2(MAX_SAMPLES + 1);
	localparam int BW  = $clog2(MAX_BINS + 1);
	localparam int BCW = $clog2(MAX_BINS);

	logic [SAMPLES_CFG_BITS-1:0] cfg_s_q;
	logic [BINS_CFG_BITS-1:0]    cfg_w_q;
	logic                        pend_q;
	logic [SW-1:0]               seen_q;
	logic [BCW-1:0]              bins_q;
	logic [SW-1:0]               nb_q;
	logic [BW-1:0]               brem_q;

	logic [31:0]    s32, w32;
	logic [SW-1:0]  eff_s;
	logic [BW-1:0]  eff_w;

	wmmd_div_stat_t div_stat;
	logic [SW-1:0]  quo;
	logic [BW-1:0]  rem;
	logic           div_start;
	logic           busy;

	logic [SW-1:0]  seen_inc;
	logic           close;
	logic           last_bin;
	logic [BW:0]    rem_sum;
	logic [BW:0]    rem_wrap;
	logic           rem_ge;
	logic [BW-1:0]  brem_nxt;
	logic [SW-1:0]  nb_nxt;
	logic [31:0]    idx32;

	// Effective S and W' after zero and oversize clamping
	always_comb begin
		s32 = 32'(cfg_s_q);
		if (s32 == 32'd0) s32 = 32'd1;
		else if (s32 > 32'(MAX_SAMPLES)) s32 = 32'(MAX_SAMPLES);
		w32 = 32'(cfg_w_q);
		if (w32 == 32'd0) w32 = 32'd1;
		else if (w32 > 32'(MAX_BINS)) w32 = 32'(MAX_BINS);
		if (w32 > s32) w32 = s32;
		eff_s = s32[SW-1:0];
		eff_w = w32[BW-1:0];
	end

	assign div_start = pend_q && !cfg_we;

	wmmd_div #(
		.N_BITS (SW),
		.D_BITS (BW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (eff_s),
		.divisor   (eff_w),
		.stat      (div_stat),
		.quotient  (quo),
		.remainder (rem)
	);

	assign busy     = pend_q || div_stat.busy || div_stat.done;
	// no sample in a write cycle: the write restarts the frame
	assign in_ready = !busy && !q_full && !cfg_we;
	assign push     = in_valid && in_ready;
	assign restart  = cfg_we;

	always_comb begin
		seen_inc = seen_q + 1'b1;
		close    = seen_inc >= nb_q;
		last_bin = (32'(bins_q) + 32'd1) >= 32'(eff_w);
		rem_sum  = {1'b0, brem_q} + {1'b0, rem};
		rem_ge   = rem_sum >= {1'b0, eff_w};
		rem_wrap = rem_sum - {1'b0, eff_w};
		brem_nxt = rem_ge ? rem_wrap[BW-1:0] : rem_sum[BW-1:0];
		nb_nxt   = nb_q + quo + SW'(rem_ge);
		idx32    = 32'(bins_q);
	end

	assign push_sample     = sample;
	assign push_ctrl.close = close;
	assign push_ctrl.last  = close && last_bin;
	assign push_ctrl.index = idx32[BIN_INDEX_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_s_q <= SAMPLES_CFG_BITS'(RESET_SAMPLES);
			cfg_w_q <= BINS_CFG_BITS'(RESET_BINS);
			pend_q  <= 1'b1;
			seen_q  <= '0;
			bins_q  <= '0;
			nb_q    <= '0;
			brem_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLES_PER_FRAME: cfg_s_q <= cfg_data[SAMPLES_CFG_BITS-1:0];
				REG_BINS_PER_FRAME:    cfg_w_q <= cfg_data[BINS_CFG_BITS-1:0];
				default:               ;
			endcase
			pend_q <= 1'b1;
			seen_q <= '0;
			bins_q <= '0;
			nb_q   <= '0;
			brem_q <= '0;
		end else begin
			if (pend_q) pend_q <= 1'b0;
			if (div_stat.done && !pend_q) begin
				// frame start: first boundary at q, remainder r
				seen_q <= '0;
				bins_q <= '0;
				nb_q   <= quo;
				brem_q <= rem;
			end else if (push) begin
				if (close && last_bin) begin
					seen_q <= '0;
					bins_q <= '0;
					nb_q   <= quo;
					brem_q <= rem;
				end else if (close) begin
					seen_q <= seen_inc;
					bins_q <= bins_q + 1'b1;
					nb_q   <= nb_nxt;
					brem_q <= brem_nxt;
				end else begin
					seen_q <= seen_inc;
				end
			end
		end
	end

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_ctrl.last |=> seen_q == '0 && bins_q == '0)
		else $error("frame counters not cleared after last bin");

	a_bin_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> 32'(bins_q) < 32'(eff_w))
		else $error("bin count beyond bins per frame");

endmodule

`default_nettype wire

// ===== hdl/wmmd_back.sv =====
// Back end: running min/max per bin, saturation and output register.
// Uses wmmd_pkg for the tag struct and output widths.
`default_nettype none

module wmmd_back #(
	parameter int SAMPLE_BITS = wmmd_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 restart,
	input  logic                                 head_valid,
	input  logic signed [SAMPLE_BITS-1:0]        head_sample,
	input  wmmd_pkg::wmmd_ctrl_t                 head_ctrl,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [wmmd_pkg::OUT_BITS-1:0] bin_min,
	output logic signed [wmmd_pkg::OUT_BITS-1:0] bin_max,
	output logic [wmmd_pkg::BIN_INDEX_BITS-1:0]  bin_index,
	output logic                                 frame_last
);
	import wmmd_pkg::*;

	localparam logic signed [SAMPLE_BITS-1:0] RUN_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] RUN_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [32:0] SAT_HI = 33'(FULL_SCALE);
	localparam logic signed [32:0] SAT_LO = -SAT_HI;

	logic signed [SAMPLE_BITS-1:0] run_min_q, run_max_q;
	logic signed [SAMPLE_BITS-1:0] new_min, new_max;
	logic signed [32:0]            ext_min, ext_max, sat_min, sat_max;
	logic                          out_valid_q;

	always_comb begin
		new_min = (head_sample < run_min_q) ? head_sample : run_min_q;
		new_max = (head_sample > run_max_q) ? head_sample : run_max_q;
		ext_min = 33'(new_min);
		ext_max = 33'(new_max);
		sat_min = (ext_min > SAT_HI) ? SAT_HI : (ext_min < SAT_LO) ? SAT_LO : ext_min;
		sat_max = (ext_max > SAT_HI) ? SAT_HI : (ext_max < SAT_LO) ? SAT_LO : ext_max;
	end

	// a closing word needs the output slot free or draining
	assign pop = head_valid && (!head_ctrl.close || !out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q   <= RUN_POS;
			run_max_q   <= RUN_NEG;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head_ctrl.close)  out_valid_q <= 1'b1;
			else if (out_ready)          out_valid_q <= 1'b0;
			if (restart || (pop && head_ctrl.close)) begin
				run_min_q <= RUN_POS;
				run_max_q <= RUN_NEG;
			end else if (pop) begin
				run_min_q <= new_min;
				run_max_q <= new_max;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_ctrl.close) begin
			bin_min    <= sat_min[OUT_BITS-1:0];
			bin_max    <= sat_max[OUT_BITS-1:0];
			bin_index  <= head_ctrl.index;
			frame_last <= head_ctrl.last;
		end
	end

	assign out_valid = out_valid_q;

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> bin_min <= bin_max)
		else $error("bin minimum above bin maximum");

endmodule

`default_nettype wire

// ===== hdl/waveform_min_max_decimator.sv =====
// Top level of the min/max waveform decimator: front end, word queue, back end.
// Depends on wmmd_pkg, wmmd_front (with wmmd_div), wmmd_queue and wmmd_back.
//
// Takes one signed sample word per cycle while in_ready is high and groups
// each frame of S samples into W' = min(W, S) bins; bin i ends after sample
// floor((i+1)*S/W'). For every bin one result word comes out: minimum and
// maximum clamped to +/-2^20, bin index and a last-of-frame flag. Sustained
// rate is one sample per clock while the receiver keeps taking results; a
// result word passes the tag queue, then sits in the output register until
// it is taken. The input side keeps running while a result waits: a 4-word
// queue separates the boundary tracker from the min/max stage, so in_ready
// only drops once that queue is full. After reset and after every
// configuration write the block takes no sample while a radix-2 divider
// forms S / W' and S mod W'; configuration writes are taken in any cycle,
// and no sample is taken in the write cycle itself. Any write, also to an
// unused index, restarts the frame and drops the samples of the unfinished
// bin. Zero in a register counts as one; values above MAX_SAMPLES /
// MAX_BINS are clamped.
`default_nettype none

module waveform_min_max_decimator #(
	parameter int MAX_BINS    = wmmd_pkg::DEF_MAX_BINS,
	parameter int MAX_SAMPLES = wmmd_pkg::DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = wmmd_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [wmmd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [wmmd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	// sample words in
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	// bin words out
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [wmmd_pkg::OUT_BITS-1:0] bin_min,
	output logic signed [wmmd_pkg::OUT_BITS-1:0] bin_max,
	output logic [wmmd_pkg::BIN_INDEX_BITS-1:0]  bin_index,
	output logic                                 frame_last
);
	import wmmd_pkg::*;

	localparam int CTRL_BITS = $bits(wmmd_ctrl_t);
	localparam int QW        = SAMPLE_BITS + CTRL_BITS;

	logic                          push, pop, q_full, q_empty, restart;
	logic signed [SAMPLE_BITS-1:0] push_sample;
	wmmd_ctrl_t                    push_ctrl;
	logic [QW-1:0]                 q_rd;
	logic signed [SAMPLE_BITS-1:0] head_sample;
	wmmd_ctrl_t                    head_ctrl;

	// Front: registers, boundary tracking, tags each accepted sample
	wmmd_front #(
		.MAX_BINS    (MAX_BINS),
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.q_full      (q_full),
		.push        (push),
		.push_sample (push_sample),
		.push_ctrl   (push_ctrl),
		.restart     (restart)
	);

	// Tagged sample queue
	wmmd_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (restart),
		.push    (push),
		.wr_data ({push_sample, push_ctrl}),
		.pop     (pop),
		.rd_data (q_rd),
		.full    (q_full),
		.empty   (q_empty)
	);

	assign head_sample = q_rd[QW-1 -: SAMPLE_BITS];
	assign head_ctrl   = wmmd_ctrl_t'(q_rd[CTRL_BITS-1:0]);

	// Back: min/max accumulation and result register
	wmmd_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (restart),
		.head_valid  (!q_empty && !restart),
		.head_sample (head_sample),
		.head_ctrl   (head_ctrl),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.bin_min     (bin_min),
		.bin_max     (bin_max),
		.bin_index   (bin_index),
		.frame_last  (frame_last)
	);

	// a register write must hold off samples until the divider has finished
	a_cfg_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("sample accepted right after configuration write");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking bench for waveform_min_max_decimator: a table of directed
// sample words, then random register settings with random samples.
// Depends on wmmd_pkg and the RTL of the block; needs no other file.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import wmmd_pkg::*;

	localparam int SW          = DEF_SAMPLE_BITS;
	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYC   = 6;
	localparam int SETTLE_CYC  = 4;    // margin for a result still in the tag queue or the output register
	localparam int END_CYC     = 10;
	localparam int HOLD_CYC    = 100;  // long receiver hold-off
	localparam int RANDOM_WORDS = 950;
	localparam int REPORT_MAX  = 10;

	// Register indexes past the end of the map: written only to restart a frame
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 2'd3;

	localparam logic signed [SW-1:0] RUN_TOP    = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] RUN_BOTTOM = {1'b1, {(SW-1){1'b0}}};

	typedef struct packed {
		logic signed [OUT_BITS-1:0] lo;
		logic signed [OUT_BITS-1:0] hi;
		logic [BIN_INDEX_BITS-1:0]  idx;
		logic                       last;
	} bin_word_t;

	// One line of the directed script: a register write or a sample word,
	// the latter optionally with a hand-written result
	typedef struct {
		bit                         is_write;
		logic [CFG_IDX_BITS-1:0]    reg_idx;
		logic [CFG_DATA_BITS-1:0]   reg_val;
		logic signed [SW-1:0]       value;
		bit                         typed;
		bin_word_t                  want;
	} script_row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_SHUT} rx_mode_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]     cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]    cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic signed [SW-1:0]        sample = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic signed [OUT_BITS-1:0]  bin_min;
	logic signed [OUT_BITS-1:0]  bin_max;
	logic [BIN_INDEX_BITS-1:0]   bin_index;
	logic                        frame_last;

	// Predictor state: register copies and the bin tracker
	logic [SAMPLES_CFG_BITS-1:0] frame_len_reg;
	logic [BINS_CFG_BITS-1:0]    bin_cnt_reg;
	logic signed [SW-1:0]        bin_lo;
	logic signed [SW-1:0]        bin_hi;
	logic [16:0]                 taken;
	logic [BIN_INDEX_BITS-1:0]   bins_closed;
	logic [15:0]                 carry;
	logic [16:0]                 boundary_at;

	bin_word_t   pending_bins[$];
	script_row_t script[$];

	int  fail_count;
	int  words_checked;
	int  clamped_words;
	int  samples_sent;
	int  settings_count;
	int  burst_left;
	int  hold_left;
	int  seg_left;
	bit  stall_req;
	rx_mode_t seg_mode;

	waveform_min_max_decimator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bin_min    (bin_min),
		.bin_max    (bin_max),
		.bin_index  (bin_index),
		.frame_last (frame_last)
	);

	always #HALF_PERIOD clk = ~clk;

	// Hard stop in case the handshake hangs
	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Effective S: zero counts as one, clamped to the build limit
	function automatic int unsigned frame_len_eff();
		int unsigned s;
		s = frame_len_reg;
		if (s == 0) s = 1;
		if (s > DEF_MAX_SAMPLES) s = DEF_MAX_SAMPLES;
		return s;
	endfunction

	// Effective W': same rules, and never more bins than samples
	function automatic int unsigned bin_cnt_eff(input int unsigned s);
		int unsigned w;
		w = bin_cnt_reg;
		if (w == 0) w = 1;
		if (w > DEF_MAX_BINS) w = DEF_MAX_BINS;
		if (w > s) w = s;
		return w;
	endfunction

	function automatic logic signed [OUT_BITS-1:0] clamp_fs(input logic signed [SW-1:0] v);
		if (v > FULL_SCALE) return OUT_BITS'(FULL_SCALE);
		if (v < -FULL_SCALE) return OUT_BITS'(-FULL_SCALE);
		return OUT_BITS'(v);
	endfunction

	function automatic void restart_frame();
		bin_lo      = RUN_TOP;
		bin_hi      = RUN_BOTTOM;
		taken       = '0;
		bins_closed = '0;
		carry       = '0;
		boundary_at = '0;
	endfunction

	// Folds one accepted sample into the current bin; returns 1 and the bin
	// word when the sample closes the bin. Boundaries come from carrying the
	// remainder of S / W' from bin to bin.
	function automatic bit fold_sample(input logic signed [SW-1:0] v, output bin_word_t word);
		int unsigned s, w, q, r;
		bit          closes_frame;
		s = frame_len_eff();
		w = bin_cnt_eff(s);
		q = s / w;
		r = s % w;
		word = '0;
		if (taken == 0) begin
			carry       = 16'(r);
			boundary_at = 17'(q);
		end
		// overrange samples are tracked at full width, clamped only on output
		if (v < bin_lo) bin_lo = v;
		if (v > bin_hi) bin_hi = v;
		taken = taken + 1'b1;
		if (taken < boundary_at) return 1'b0;

		closes_frame = (bins_closed + 1 >= w);
		word.lo   = clamp_fs(bin_lo);
		word.hi   = clamp_fs(bin_hi);
		word.idx  = bins_closed;
		word.last = closes_frame;
		bin_lo = RUN_TOP;
		bin_hi = RUN_BOTTOM;
		if (closes_frame) begin
			taken       = '0;
			bins_closed = '0;
			carry       = '0;
			boundary_at = '0;
		end else begin
			bins_closed = bins_closed + 1'b1;
			carry       = carry + 16'(r);
			boundary_at = boundary_at + 17'(q);
			if (carry >= w) begin
				carry       = carry - 16'(w);
				boundary_at = boundary_at + 1'b1;
			end
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Directed script rows
	// ------------------------------------------------------------------

	function automatic script_row_t row_write(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		script_row_t row;
		row = '{default: '0};
		row.is_write = 1'b1;
		row.reg_idx  = idx;
		row.reg_val  = val;
		return row;
	endfunction

	function automatic script_row_t row_sample(input logic signed [SW-1:0] v);
		script_row_t row;
		row = '{default: '0};
		row.value = v;
		return row;
	endfunction

	// Sample that closes a bin whose result is obvious by hand
	function automatic script_row_t row_known(input logic signed [SW-1:0] v,
			input int lo, input int hi, input int idx, input bit last);
		script_row_t row;
		row = row_sample(v);
		row.typed     = 1'b1;
		row.want.lo   = OUT_BITS'(lo);
		row.want.hi   = OUT_BITS'(hi);
		row.want.idx  = BIN_INDEX_BITS'(idx);
		row.want.last = last;
		return row;
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offers one sample word and holds it until taken; the expected bin word,
	// if the sample closes a bin, is queued at the accepting edge.
	task automatic offer_sample(input logic signed [SW-1:0] v, input bit typed,
			input bin_word_t want);
		bin_word_t word;
		@(negedge clk);
		in_valid <= 1'b1;
		sample   <= v;
		do @(posedge clk); while (in_ready !== 1'b1);
		samples_sent++;
		if (fold_sample(v, word))
			pending_bins.push_back(typed ? want : word);
	endtask

	// Drops in_valid for a gap whose length is given by n, with junk on the data lines
	task automatic idle_gap(input int n);
		@(negedge clk);
		in_valid <= 1'b0;
		sample   <= SW'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	// Burst pacing: random burst lengths, often with a random gap in front
	task automatic pace_sender();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
		end
		burst_left--;
	endtask

	// Stop sending and wait until every predicted bin word has come out,
	// plus a settling margin for a bin still closing inside the pipe
	task automatic drain_bins();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_bins.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Single-cycle register write; every write restarts the frame
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_SAMPLES_PER_FRAME: frame_len_reg = val;
			REG_BINS_PER_FRAME:    bin_cnt_reg = val[BINS_CFG_BITS-1:0];
			default: ;
		endcase
		restart_frame();
		settings_count++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mix of in-range, near-full-scale, overrange and extreme samples
	function automatic logic signed [SW-1:0] rand_sample();
		int v;
		case ($urandom_range(0, 6))
			0: v = int'($urandom);
			1: v = int'($urandom_range(0, 2 * FULL_SCALE)) - FULL_SCALE;
			2: v = FULL_SCALE - 2 + int'($urandom_range(0, 4));
			3: v = -FULL_SCALE - 2 + int'($urandom_range(0, 4));
			4: v = $urandom_range(0, 1) ? int'(RUN_TOP) : int'(RUN_BOTTOM);
			5: v = int'($urandom_range(0, 255)) - 128;
			default: v = int'($urandom_range(0, 6 * FULL_SCALE)) - 3 * FULL_SCALE;
		endcase
		return SW'(v);
	endfunction

	// One random register setting followed by a run of samples. Phase 0 is
	// the squeeze: one bin per sample, receiver held off, sender gapless, so
	// the result queue fills and in_ready has to drop.
	task automatic random_phase(input int phase_no);
		int        s_val, w_val, n_words, mid;
		bit        squeeze;
		bin_word_t unused;
		squeeze = (phase_no == 0);
		unused  = '0;
		if (squeeze) begin
			s_val = 8;
			w_val = 8;
		end else begin
			case ($urandom_range(0, 9))
				0: begin   // S zero or one: single-sample frames
					s_val = $urandom_range(0, 1);
					w_val = $urandom_range(0, 600);
				end
				1: begin   // W zero or one, upper data bits masked off
					s_val = $urandom_range(1, 60);
					w_val = $urandom_range(0, 1) | ($urandom_range(0, 3) << BINS_CFG_BITS);
				end
				2: begin
					s_val = $urandom_range(1, 40);
					w_val = s_val;
				end
				3: begin   // at least as many bins as samples
					s_val = $urandom_range(1, 30);
					w_val = $urandom_range(s_val, 32767);
				end
				4: begin   // both at or above the build limits, bins of four
					s_val = $urandom_range(DEF_MAX_SAMPLES, 131071);
					w_val = $urandom_range(DEF_MAX_BINS, 32767);
				end
				5: begin
					s_val = $urandom_range(1000, 20000);
					w_val = s_val / $urandom_range(2, 5);
				end
				default: begin
					s_val = $urandom_range(2, 200);
					w_val = $urandom_range(1, s_val);
				end
			endcase
		end

		drain_bins();
		if ($urandom_range(0, 3) == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
				CFG_DATA_BITS'($urandom));
		if ($urandom_range(0, 1)) begin
			write_reg(REG_SAMPLES_PER_FRAME, CFG_DATA_BITS'(s_val));
			write_reg(REG_BINS_PER_FRAME, CFG_DATA_BITS'(w_val));
		end else begin
			write_reg(REG_BINS_PER_FRAME, CFG_DATA_BITS'(w_val));
			write_reg(REG_SAMPLES_PER_FRAME, CFG_DATA_BITS'(s_val));
		end

		n_words = squeeze ? 120 : $urandom_range(20, 90);
		// every fifth phase the sender stops halfway until the output side is empty
		mid = (phase_no % 5 == 2) ? n_words / 2 : -1;
		if (squeeze) stall_req = 1'b1;
		for (int i = 0; i < n_words; i++) begin
			if (i == mid) drain_bins();
			if (!squeeze) pace_sender();
			offer_sample(rand_sample(), 1'b0, unused);
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver side: segments of open, coin-flip, sparse and shut ready,
	// plus one long hold-off on request, counted here in cycles.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (stall_req) begin
			stall_req = 1'b0;
			hold_left = HOLD_CYC - 1;
			out_ready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_mode = rx_mode_t'($urandom_range(0, 3));
				seg_left = (seg_mode == RX_SHUT) ? $urandom_range(4, 30) :
					$urandom_range(16, 160);
			end
			seg_left--;
			case (seg_mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= $urandom_range(0, 1);
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:   out_ready <= 1'b0;
			endcase
		end
	end

	// Scoreboard: each accepted bin word against the oldest prediction
	always @(posedge clk) begin
		bin_word_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			words_checked++;
			if (bin_min == -FULL_SCALE || bin_max == FULL_SCALE) clamped_words++;
			if (pending_bins.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("%0t: bin word with none expected: min %0d max %0d idx %0d last %0b",
						$realtime, bin_min, bin_max, bin_index, frame_last);
			end else begin
				want = pending_bins.pop_front();
				if (bin_min !== want.lo || bin_max !== want.hi ||
						bin_index !== want.idx || frame_last !== want.last) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("%0t: bin mismatch: want min %0d max %0d idx %0d last %0b, got min %0d max %0d idx %0d last %0b",
							$realtime, want.lo, want.hi, want.idx, want.last,
							bin_min, bin_max, bin_index, frame_last);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int phase_no;
		int directed_words;
		fail_count     = 0;
		words_checked  = 0;
		clamped_words  = 0;
		samples_sent   = 0;
		settings_count = 0;
		burst_left     = 0;
		hold_left      = 0;
		seg_left       = 0;
		stall_req      = 1'b0;
		seg_mode       = RX_OPEN;
		frame_len_reg  = RESET_SAMPLES;
		bin_cnt_reg    = RESET_BINS;
		restart_frame();

		// Reset default 1024/512: two samples per bin
		script.push_back(row_sample(RUN_TOP));
		script.push_back(row_known(RUN_BOTTOM, -FULL_SCALE, FULL_SCALE, 0, 1'b0));
		script.push_back(row_sample(FULL_SCALE + 1));
		script.push_back(row_known(-FULL_SCALE - 1, -FULL_SCALE, FULL_SCALE, 1, 1'b0));
		// S written as zero acts as one, W' follows down to one
		script.push_back(row_write(REG_SAMPLES_PER_FRAME, '0));
		script.push_back(row_known(FULL_SCALE, FULL_SCALE, FULL_SCALE, 0, 1'b1));
		script.push_back(row_known(-FULL_SCALE, -FULL_SCALE, -FULL_SCALE, 0, 1'b1));
		script.push_back(row_known(0, 0, 0, 0, 1'b1));
		script.push_back(row_known(-1, -1, -1, 0, 1'b1));
		// W zero acts as one: one bin of three
		script.push_back(row_write(REG_SAMPLES_PER_FRAME, 17'd3));
		script.push_back(row_write(REG_BINS_PER_FRAME, '0));
		script.push_back(row_sample(5));
		script.push_back(row_sample(-7));
		script.push_back(row_known(2, -7, 5, 0, 1'b1));
		// write to an unmapped index drops the partial bin
		script.push_back(row_sample(100));
		script.push_back(row_write(REG_SPARE_HI, '1));
		script.push_back(row_sample(9));
		script.push_back(row_sample(-3));
		script.push_back(row_known(4, -3, 9, 0, 1'b1));
		// S=5, W=2: uneven bins of two and three
		script.push_back(row_write(REG_SAMPLES_PER_FRAME, 17'd5));
		script.push_back(row_write(REG_BINS_PER_FRAME, 17'd2));
		script.push_back(row_sample(24'sh555555));
		script.push_back(row_sample(24'sh2AAAAA));
		script.push_back(row_sample(1));
		script.push_back(row_sample(-2));
		script.push_back(row_sample(RUN_BOTTOM));
		// both registers beyond the limits: clamped, bins of four
		script.push_back(row_write(REG_SAMPLES_PER_FRAME, '1));
		script.push_back(row_write(REG_BINS_PER_FRAME, 17'h7FFF));
		script.push_back(row_sample(-1));
		script.push_back(row_sample(0));
		script.push_back(row_sample(12345));
		script.push_back(row_sample(-FULL_SCALE));
		// W data with only bits above the register width set reads as zero
		script.push_back(row_write(REG_SAMPLES_PER_FRAME, 17'd2));
		script.push_back(row_write(REG_BINS_PER_FRAME, 17'h18000));
		script.push_back(row_sample(3));
		script.push_back(row_known(-4, -4, 3, 0, 1'b1));

		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_write) begin
				drain_bins();
				write_reg(script[i].reg_idx, script[i].reg_val);
			end else begin
				offer_sample(script[i].value, script[i].typed, script[i].want);
			end
		end
		directed_words = samples_sent;

		phase_no = 0;
		while (samples_sent < directed_words + RANDOM_WORDS) begin
			random_phase(phase_no);
			phase_no++;
		end

		drain_bins();
		repeat (END_CYC) @(posedge clk);

		$display("Covered %0d sample words under %0d register writes; %0d bin words checked, %0d of them clamped",
			samples_sent, settings_count, words_checked, clamped_words);
		if (fail_count == 0 && pending_bins.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d failing bin words, %0d still expected", fail_count,
				pending_bins.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
